### design/ipv6_dad_pkg.sv
// types and constants shared by the duplicate address detection table
// no dependencies
`timescale 1ns / 1ps
package ipv6_dad_pkg;

	localparam logic [2:0] ACT_START = 3'd0;
	localparam logic [2:0] ACT_STOP  = 3'd1;
	localparam logic [2:0] ACT_FIND  = 3'd2;
	localparam logic [2:0] ACT_NS    = 3'd3;
	localparam logic [2:0] ACT_NA    = 3'd4;
	localparam logic [2:0] ACT_TICK  = 3'd5;

	localparam logic [2:0] PH_FREE    = 3'd0;
	localparam logic [2:0] PH_DELAY   = 3'd1;
	localparam logic [2:0] PH_PROBING = 3'd2;
	localparam logic [2:0] PH_WAIT    = 3'd3;
	localparam logic [2:0] PH_UNIQUE  = 3'd4;
	localparam logic [2:0] PH_DUP     = 3'd5;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_BUSY = 2'd1;
	localparam logic [1:0] ST_ERR  = 2'd2;

	localparam logic [1:0] SEND_NONE = 2'd0;
	localparam logic [1:0] SEND_NS   = 2'd1;
	localparam logic [1:0] SEND_JOIN = 2'd2;

	localparam logic [1:0] VERD_NONE = 2'd0;
	localparam logic [1:0] VERD_UNIQ = 2'd1;
	localparam logic [1:0] VERD_DUP  = 2'd2;

	localparam logic [1:0] REG_TRANSMIT = 2'd0;
	localparam logic [1:0] REG_LOOPBACK = 2'd1;
	localparam logic [1:0] REG_RETRANS  = 2'd2;
	localparam logic [1:0] REG_MAXDELAY = 2'd3;

	typedef struct packed {
		logic [2:0]  action;
		logic [63:0] addr_hi;
		logic [63:0] addr_lo;
		logic [31:0] now_ms;
		logic [31:0] rexmit_ms;
		logic [15:0] rand_word;
		logic        use_delay;
		logic        is_anycast;
		logic        hw_based;
		logic        src_unspecified;
	} dad_in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  entry;
		logic [2:0]  entry_state;
		logic [7:0]  sent_count;
		logic [7:0]  received_count;
		logic [63:0] deadline;
		logic [1:0]  send_kind;
		logic [1:0]  verdict;
		logic        ip_down;
		logic        tentative;
		logic [63:0] target_hi;
		logic [63:0] target_lo;
	} dad_out_t;

	// controller to datapath
	typedef struct packed {
		logic capture;   // register the transaction
		logic scan_clr;  // reset scan pointer and flags
		logic scan_step; // examine one slot
		logic mul;       // register delay product
		logic exec;      // apply action, build result
	} dad_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_last;
	} dad_stat_t;

endpackage

### design/ipv6_dad_ctrl.sv
// sequencer for one transaction: capture, slot scan, multiply, execute, report
// depends on ipv6_dad_pkg
`timescale 1ns / 1ps
module ipv6_dad_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	output logic                   done,
	output ipv6_dad_pkg::dad_cmd_t cmd,
	input  ipv6_dad_pkg::dad_stat_t stat
);
	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_MUL, S_EXEC, S_DONE} state_t;
	state_t state_q;

	// one state register plus registered busy/done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy    <= 1'b0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_SCAN;
						busy    <= 1'b1;
					end
				end
				S_SCAN: begin
					if (stat.scan_last) state_q <= S_MUL;
				end
				S_MUL: state_q <= S_EXEC;
				S_EXEC: begin
					state_q <= S_DONE;
					done    <= 1'b1;
				end
				S_DONE: begin
					state_q <= S_IDLE;
					busy    <= 1'b0;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// commands
	always_comb begin
		cmd.capture   = (state_q == S_IDLE) && start;
		cmd.scan_clr  = (state_q == S_IDLE) && start;
		cmd.scan_step = (state_q == S_SCAN);
		cmd.mul       = (state_q == S_MUL);
		cmd.exec      = (state_q == S_EXEC);
	end
endmodule

### design/ipv6_dad_dp.sv
// slot table, clock extension and result formation
// depends on ipv6_dad_pkg
`timescale 1ns / 1ps
module ipv6_dad_dp #(
	parameter int ENTRIES = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ipv6_dad_pkg::dad_in_t   item,
	input  ipv6_dad_pkg::dad_cmd_t  cmd,
	output ipv6_dad_pkg::dad_stat_t stat,
	input  logic [7:0]              cfg_tx,
	input  logic                    cfg_loop,
	input  logic [31:0]             cfg_retrans,
	input  logic [15:0]             cfg_maxdelay,
	output ipv6_dad_pkg::dad_out_t  res
);
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam logic [CW-1:0] NONE = CW'(ENTRIES);

	logic              used_q [ENTRIES];
	logic [63:0]       ahi_q  [ENTRIES];
	logic [63:0]       alo_q  [ENTRIES];
	logic [2:0]        ph_q   [ENTRIES];
	logic [7:0]        sent_q [ENTRIES];
	logic [7:0]        rcv_q  [ENTRIES];
	logic [31:0]       rtx_q  [ENTRIES];
	logic [63:0]       dl_q   [ENTRIES];
	logic              hw_q   [ENTRIES];
	logic [31:0]       clk_lo_q, clk_hi_q;

	ipv6_dad_pkg::dad_in_t in_q;
	logic [CW-1:0]     ptr_q;
	logic [CW-1:0]     match_q, free_q, due_q;
	logic [63:0]       now64_q;
	logic [47:0]       prod_q;

	logic [IW-1:0] pi;
	assign pi = ptr_q[IW-1:0];
	assign stat.scan_last = (ptr_q == NONE - CW'(1));

	// extended clock for this transaction
	logic [31:0] hi_next;
	assign hi_next = (in_q.now_ms < clk_lo_q) ? clk_hi_q + 32'd1 : clk_hi_q;

	// scan: one slot per cycle for match, free and due
	logic ptr_tent;
	assign ptr_tent = (ph_q[pi] == ipv6_dad_pkg::PH_DELAY) ||
		(ph_q[pi] == ipv6_dad_pkg::PH_PROBING) || (ph_q[pi] == ipv6_dad_pkg::PH_WAIT);

	always_ff @(posedge clk) begin
		if (cmd.capture) in_q <= item;
		if (cmd.scan_clr) begin
			ptr_q   <= '0;
			match_q <= NONE;
			free_q  <= NONE;
			due_q   <= NONE;
		end else if (cmd.scan_step) begin
			ptr_q <= ptr_q + CW'(1);
			if (match_q == NONE && used_q[pi] && ahi_q[pi] == in_q.addr_hi &&
			    alo_q[pi] == in_q.addr_lo) match_q <= ptr_q;
			if (free_q == NONE && !used_q[pi]) free_q <= ptr_q;
			if (due_q == NONE && used_q[pi] && ptr_tent &&
			    !({hi_next, in_q.now_ms} < dl_q[pi])) due_q <= ptr_q;
			now64_q <= {hi_next, in_q.now_ms};
		end
		if (cmd.mul)
			prod_q <= {32'd0, in_q.rand_word} * {31'd0, {1'b0, cfg_maxdelay} + 17'd1};
	end

	// execute stage
	logic [IW-1:0] m, f, d;
	assign m = match_q[IW-1:0];
	assign f = free_q[IW-1:0];
	assign d = due_q[IW-1:0];
	logic start_ok, m_tent, d_next_wait, m_ll;
	logic [7:0] d_sent1, m_rcv1;
	logic [7:0] exp_cnt;
	logic m_cnt, m_dup;
	logic [63:0] start_dl, tick_dl;
	assign start_ok = in_q.addr_hi[63:56] != 8'hFF &&
		!(in_q.addr_hi == 64'd0 && in_q.addr_lo == 64'd0) && !in_q.is_anycast &&
		match_q == NONE;
	assign m_tent = (ph_q[m] == ipv6_dad_pkg::PH_DELAY) ||
		(ph_q[m] == ipv6_dad_pkg::PH_PROBING) || (ph_q[m] == ipv6_dad_pkg::PH_WAIT);
	assign d_sent1 = sent_q[d] + 8'd1;
	assign d_next_wait = d_sent1 >= cfg_tx;
	assign m_ll = ahi_q[m][63:56] == 8'hFE && (ahi_q[m][55:48] & 8'hC0) == 8'h80;
	assign m_rcv1 = (rcv_q[m] < 8'hFF) ? rcv_q[m] + 8'd1 : rcv_q[m];
	assign exp_cnt = cfg_loop ? sent_q[m] : 8'd0;
	assign start_dl = now64_q + (in_q.use_delay ? 64'(prod_q[47:16]) : 64'd0);
	assign tick_dl = now64_q + 64'(rtx_q[d]);

	// solicitation counted, and duplicate detected, on the matched slot
	assign m_cnt = m_tent && in_q.action == ipv6_dad_pkg::ACT_NS && in_q.src_unspecified &&
		sent_q[m] != 8'd0;
	assign m_dup = m_tent && (in_q.action == ipv6_dad_pkg::ACT_NA ||
		(in_q.action == ipv6_dad_pkg::ACT_NS && in_q.src_unspecified &&
		(sent_q[m] == 8'd0 || m_rcv1 > exp_cnt)));

	// result for the current transaction
	ipv6_dad_pkg::dad_out_t res_d;
	always_comb begin
		res_d = '0;
		res_d.status = ipv6_dad_pkg::ST_ERR;
		res_d.entry  = 4'(ENTRIES);
		case (in_q.action)
			ipv6_dad_pkg::ACT_START: begin
				if (start_ok && free_q == NONE) begin
					res_d.status = ipv6_dad_pkg::ST_BUSY;
				end else if (start_ok) begin
					res_d.status = ipv6_dad_pkg::ST_OK;
					res_d.entry  = 4'(free_q);
					res_d.target_hi = in_q.addr_hi;
					res_d.target_lo = in_q.addr_lo;
					if (cfg_tx == 8'd0) begin
						res_d.entry_state = ipv6_dad_pkg::PH_UNIQUE;
						res_d.verdict = ipv6_dad_pkg::VERD_UNIQ;
					end else begin
						res_d.entry_state = ipv6_dad_pkg::PH_DELAY;
						res_d.deadline = start_dl;
					end
				end
			end
			ipv6_dad_pkg::ACT_STOP: begin
				if (match_q != NONE) begin
					res_d.status = ipv6_dad_pkg::ST_OK;
					res_d.entry  = 4'(match_q);
				end
			end
			ipv6_dad_pkg::ACT_FIND, ipv6_dad_pkg::ACT_NS, ipv6_dad_pkg::ACT_NA: begin
				if (in_q.action != ipv6_dad_pkg::ACT_FIND)
					res_d.status = ipv6_dad_pkg::ST_OK;
				if (match_q != NONE) begin
					res_d.status = ipv6_dad_pkg::ST_OK;
					res_d.entry = 4'(match_q);
					res_d.entry_state = ph_q[m];
					res_d.sent_count = sent_q[m];
					res_d.received_count = m_cnt ? m_rcv1 : rcv_q[m];
					res_d.deadline = dl_q[m];
					res_d.target_hi = ahi_q[m];
					res_d.target_lo = alo_q[m];
					res_d.tentative = m_tent;
					if (m_dup) begin
						res_d.entry_state = ipv6_dad_pkg::PH_DUP;
						res_d.deadline = '0;
						res_d.verdict = ipv6_dad_pkg::VERD_DUP;
						res_d.ip_down = hw_q[m] && m_ll;
					end
				end
			end
			ipv6_dad_pkg::ACT_TICK: begin
				res_d.status = ipv6_dad_pkg::ST_BUSY;
				if (due_q != NONE) begin
					res_d.status = ipv6_dad_pkg::ST_OK;
					res_d.entry = 4'(due_q);
					res_d.received_count = rcv_q[d];
					res_d.target_hi = ahi_q[d];
					res_d.target_lo = alo_q[d];
					if (ph_q[d] == ipv6_dad_pkg::PH_WAIT) begin
						res_d.entry_state = ipv6_dad_pkg::PH_UNIQUE;
						res_d.sent_count = sent_q[d];
						res_d.verdict = ipv6_dad_pkg::VERD_UNIQ;
					end else begin
						res_d.entry_state = d_next_wait ? ipv6_dad_pkg::PH_WAIT
							: ipv6_dad_pkg::PH_PROBING;
						res_d.sent_count = d_sent1;
						res_d.deadline = tick_dl;
						res_d.send_kind = (ph_q[d] == ipv6_dad_pkg::PH_DELAY)
							? ipv6_dad_pkg::SEND_JOIN : ipv6_dad_pkg::SEND_NS;
					end
				end
			end
			default: ;
		endcase
	end

	// slot and clock updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ENTRIES; k++) begin
				used_q[k] <= 1'b0;
				ph_q[k]   <= ipv6_dad_pkg::PH_FREE;
				sent_q[k] <= '0;
				rcv_q[k]  <= '0;
				dl_q[k]   <= '0;
				hw_q[k]   <= 1'b0;
			end
			clk_lo_q <= '0;
			clk_hi_q <= '0;
			res      <= '0;
		end else if (cmd.exec) begin
			res <= res_d;
			case (in_q.action)
				ipv6_dad_pkg::ACT_START: begin
					if (start_ok && free_q != NONE) begin
						used_q[f] <= 1'b1;
						ahi_q[f]  <= in_q.addr_hi;
						alo_q[f]  <= in_q.addr_lo;
						rtx_q[f]  <= (in_q.rexmit_ms != 32'd0) ? in_q.rexmit_ms : cfg_retrans;
						sent_q[f] <= '0;
						rcv_q[f]  <= '0;
						hw_q[f]   <= in_q.hw_based;
						if (cfg_tx == 8'd0) begin
							ph_q[f] <= ipv6_dad_pkg::PH_UNIQUE;
							dl_q[f] <= '0;
						end else begin
							clk_lo_q <= in_q.now_ms;
							clk_hi_q <= now64_q[63:32];
							ph_q[f] <= ipv6_dad_pkg::PH_DELAY;
							dl_q[f] <= start_dl;
						end
					end
				end
				ipv6_dad_pkg::ACT_STOP: begin
					if (match_q != NONE) begin
						used_q[m] <= 1'b0;
						ahi_q[m]  <= '0;
						alo_q[m]  <= '0;
						ph_q[m]   <= ipv6_dad_pkg::PH_FREE;
						sent_q[m] <= '0;
						rcv_q[m]  <= '0;
						rtx_q[m]  <= '0;
						dl_q[m]   <= '0;
						hw_q[m]   <= 1'b0;
					end
				end
				ipv6_dad_pkg::ACT_NS, ipv6_dad_pkg::ACT_NA: begin
					if (match_q != NONE) begin
						if (m_cnt) rcv_q[m] <= m_rcv1;
						if (m_dup) begin
							ph_q[m] <= ipv6_dad_pkg::PH_DUP;
							dl_q[m] <= '0;
						end
					end
				end
				ipv6_dad_pkg::ACT_TICK: begin
					clk_lo_q <= in_q.now_ms;
					clk_hi_q <= now64_q[63:32];
					if (due_q != NONE) begin
						if (ph_q[d] == ipv6_dad_pkg::PH_WAIT) begin
							ph_q[d] <= ipv6_dad_pkg::PH_UNIQUE;
							dl_q[d] <= '0;
						end else begin
							sent_q[d] <= d_sent1;
							dl_q[d] <= tick_dl;
							ph_q[d] <= d_next_wait ? ipv6_dad_pkg::PH_WAIT
								: ipv6_dad_pkg::PH_PROBING;
						end
					end
				end
				default: ;
			endcase
		end
	end
endmodule

### design/ipv6_dad_table_machine.sv
// top level of the duplicate address detection table
// depends on ipv6_dad_pkg, ipv6_dad_ctrl, ipv6_dad_dp
`timescale 1ns / 1ps
// Each transaction runs from start to done through the scan, multiply and execute states:
// the scan examines one slot per cycle for the address, free-slot and due-deadline search,
// then the multiply state registers the random delay product and execute updates the slot.
// The result stands on result in the single cycle in which done is high; the receiver cannot stall it,
// and busy falls in the cycle after done. Configuration writes are always ready.
module ipv6_dad_table_machine #(
	parameter int ENTRIES = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  ipv6_dad_pkg::dad_in_t  item,
	output logic                   done,
	output ipv6_dad_pkg::dad_out_t result,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [1:0]             cfg_index,
	input  logic [31:0]            cfg_data
);
	ipv6_dad_pkg::dad_cmd_t  cmd;
	ipv6_dad_pkg::dad_stat_t stat;
	logic [7:0]  tx_q;
	logic        loop_q;
	logic [31:0] retrans_q;
	logic [15:0] maxdelay_q;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_q       <= 8'd1;
			loop_q     <= 1'b0;
			retrans_q  <= 32'd1000;
			maxdelay_q <= 16'd1000;
		end else if (cfg_valid) begin
			case (cfg_index)
				ipv6_dad_pkg::REG_TRANSMIT: tx_q       <= cfg_data[7:0];
				ipv6_dad_pkg::REG_LOOPBACK: loop_q     <= cfg_data[0];
				ipv6_dad_pkg::REG_RETRANS:  retrans_q  <= cfg_data;
				ipv6_dad_pkg::REG_MAXDELAY: maxdelay_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	ipv6_dad_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.cmd(cmd), .stat(stat)
	);

	ipv6_dad_dp #(.ENTRIES(ENTRIES)) u_dp (
		.clk(clk), .arst_n(arst_n), .item(item), .cmd(cmd), .stat(stat),
		.cfg_tx(tx_q), .cfg_loop(loop_q), .cfg_retrans(retrans_q),
		.cfg_maxdelay(maxdelay_q), .res(result)
	);

`ifndef ASSERT_OFF
	// a result appears only while a transaction is in flight
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("done without busy");
	// done is a single cycle strobe
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("done held");
	// an accepted start raises busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("start not taken");
`endif
endmodule

### tb/tb_ipv6_dad_table_machine.sv
// testbench for the duplicate address detection table
// depends on ipv6_dad_pkg and ipv6_dad_table_machine; predicts every result and checks it
`timescale 1ns / 1ps
module tb_ipv6_dad_table_machine;

	localparam int NSLOT = 8;
	// action codes the table does not define
	localparam logic [2:0] ACT_UNDEF_A = 3'd6;
	localparam logic [2:0] ACT_UNDEF_B = 3'd7;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	ipv6_dad_pkg::dad_in_t item;
	logic done;
	ipv6_dad_pkg::dad_out_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;

	ipv6_dad_table_machine #(.ENTRIES(NSLOT)) uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state
	logic        tbl_used [NSLOT];
	logic [63:0] tbl_hi [NSLOT];
	logic [63:0] tbl_lo [NSLOT];
	logic [2:0]  tbl_phase [NSLOT];
	logic [7:0]  tbl_sent [NSLOT];
	logic [7:0]  tbl_rcvd [NSLOT];
	logic [31:0] tbl_retr [NSLOT];
	logic [63:0] tbl_dl [NSLOT];
	logic        tbl_hw [NSLOT];
	logic [31:0] clk_lo, clk_hi;
	logic [7:0]  c_xmit;
	logic        c_loop;
	logic [31:0] c_retr;
	logic [15:0] c_maxd;

	ipv6_dad_pkg::dad_out_t expected_q[$];
	int errors = 0;
	int n_items = 0;
	int n_results = 0;
	bit idle_on = 1;
	logic [63:0] pool_hi [6];
	logic [63:0] pool_lo [6];
	logic [31:0] now_clk = '0;

	// clock
	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// limit
	initial begin
		#40ms;
		$display("Regression FAIL");
		$finish;
	end

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		errors++;
		$display("mismatch %s: got %h want %h (result %0d)", what, got, want, n_results);
	endtask

	function automatic logic [63:0] extend_now(input logic [31:0] now);
		if (now < clk_lo) clk_hi = clk_hi + 32'd1;
		clk_lo = now;
		return {clk_hi, now};
	endfunction

	function automatic int find_slot(input logic [63:0] hi, input logic [63:0] lo);
		for (int i = 0; i < NSLOT; i++)
			if (tbl_used[i] && tbl_hi[i] == hi && tbl_lo[i] == lo) return i;
		return NSLOT;
	endfunction

	function automatic bit pending(input int i);
		return tbl_phase[i] == ipv6_dad_pkg::PH_DELAY ||
			tbl_phase[i] == ipv6_dad_pkg::PH_PROBING || tbl_phase[i] == ipv6_dad_pkg::PH_WAIT;
	endfunction

	function automatic void clear_entry(input int i);
		tbl_used[i] = 0; tbl_hi[i] = '0; tbl_lo[i] = '0; tbl_phase[i] = ipv6_dad_pkg::PH_FREE;
		tbl_sent[i] = '0; tbl_rcvd[i] = '0; tbl_retr[i] = '0; tbl_dl[i] = '0; tbl_hw[i] = 0;
	endfunction

	function automatic void fill(ref ipv6_dad_pkg::dad_out_t r, input int i);
		r.entry = i[3:0];
		r.entry_state = tbl_phase[i];
		r.sent_count = tbl_sent[i];
		r.received_count = tbl_rcvd[i];
		r.deadline = tbl_dl[i];
		r.target_hi = tbl_hi[i];
		r.target_lo = tbl_lo[i];
	endfunction

	function automatic void set_dup(ref ipv6_dad_pkg::dad_out_t r, input int i);
		tbl_phase[i] = ipv6_dad_pkg::PH_DUP;
		tbl_dl[i] = '0;
		r.verdict = ipv6_dad_pkg::VERD_DUP;
		r.ip_down = tbl_hw[i] && tbl_hi[i][63:56] == 8'hFE && tbl_hi[i][55:54] == 2'b10;
	endfunction

	function automatic void set_unique(ref ipv6_dad_pkg::dad_out_t r, input int i);
		tbl_phase[i] = ipv6_dad_pkg::PH_UNIQUE;
		tbl_dl[i] = '0;
		r.verdict = ipv6_dad_pkg::VERD_UNIQ;
	endfunction

	function automatic void send_probe(ref ipv6_dad_pkg::dad_out_t r, input int i,
		input logic [63:0] t);
		if (r.send_kind == ipv6_dad_pkg::SEND_NONE) r.send_kind = ipv6_dad_pkg::SEND_NS;
		tbl_sent[i] = tbl_sent[i] + 8'd1;
		tbl_dl[i] = t + {32'd0, tbl_retr[i]};
		tbl_phase[i] = (tbl_sent[i] >= c_xmit) ? ipv6_dad_pkg::PH_WAIT : ipv6_dad_pkg::PH_PROBING;
	endfunction

	// what the table answers to one action
	function automatic ipv6_dad_pkg::dad_out_t dad_predict(input ipv6_dad_pkg::dad_in_t x);
		ipv6_dad_pkg::dad_out_t r;
		int i;
		bit tent;
		logic [63:0] t;
		logic [7:0] lim;
		r = '0;
		r.status = ipv6_dad_pkg::ST_ERR;
		r.entry = 4'(NSLOT);
		case (x.action)
			ipv6_dad_pkg::ACT_START: begin
				if (x.addr_hi[63:56] == 8'hFF || (x.addr_hi == 64'd0 && x.addr_lo == 64'd0) ||
				    x.is_anycast)
					return r;
				if (find_slot(x.addr_hi, x.addr_lo) != NSLOT) return r;
				for (i = 0; i < NSLOT; i++) if (!tbl_used[i]) break;
				if (i == NSLOT) begin
					r.status = ipv6_dad_pkg::ST_BUSY;
					return r;
				end
				tbl_hi[i] = x.addr_hi; tbl_lo[i] = x.addr_lo;
				tbl_retr[i] = x.rexmit_ms != 32'd0 ? x.rexmit_ms : c_retr;
				tbl_sent[i] = '0; tbl_rcvd[i] = '0; tbl_hw[i] = x.hw_based; tbl_used[i] = 1;
				if (c_xmit == 8'd0) set_unique(r, i);
				else begin
					t = extend_now(x.now_ms);
					tbl_phase[i] = ipv6_dad_pkg::PH_DELAY;
					if (x.use_delay)
						t = t + ((64'(x.rand_word) * (64'(c_maxd) + 64'd1)) >> 16);
					tbl_dl[i] = t;
				end
				fill(r, i);
				r.status = ipv6_dad_pkg::ST_OK;
			end
			ipv6_dad_pkg::ACT_STOP: begin
				i = find_slot(x.addr_hi, x.addr_lo);
				if (i == NSLOT) return r;
				clear_entry(i);
				r.entry = i[3:0];
				r.status = ipv6_dad_pkg::ST_OK;
			end
			ipv6_dad_pkg::ACT_FIND: begin
				i = find_slot(x.addr_hi, x.addr_lo);
				if (i == NSLOT) return r;
				fill(r, i);
				r.tentative = pending(i);
				r.status = ipv6_dad_pkg::ST_OK;
			end
			ipv6_dad_pkg::ACT_NS, ipv6_dad_pkg::ACT_NA: begin
				r.status = ipv6_dad_pkg::ST_OK;
				i = find_slot(x.addr_hi, x.addr_lo);
				if (i == NSLOT) return r;
				tent = pending(i);
				if (x.action == ipv6_dad_pkg::ACT_NA) begin
					if (tent) set_dup(r, i);
				end else if (tent && x.src_unspecified) begin
					if (tbl_sent[i] == 8'd0) set_dup(r, i);
					else begin
						if (tbl_rcvd[i] != 8'hFF) tbl_rcvd[i] = tbl_rcvd[i] + 8'd1;
						lim = c_loop ? tbl_sent[i] : 8'd0;
						if (tbl_rcvd[i] > lim) set_dup(r, i);
					end
				end
				fill(r, i);
				r.tentative = tent;
			end
			ipv6_dad_pkg::ACT_TICK: begin
				t = extend_now(x.now_ms);
				r.status = ipv6_dad_pkg::ST_BUSY;
				for (i = 0; i < NSLOT; i++) begin
					if (!tbl_used[i] || !pending(i) || t < tbl_dl[i]) continue;
					if (tbl_phase[i] == ipv6_dad_pkg::PH_DELAY) begin
						r.send_kind = ipv6_dad_pkg::SEND_JOIN;
						send_probe(r, i, t);
					end else if (tbl_phase[i] == ipv6_dad_pkg::PH_PROBING) send_probe(r, i, t);
					else set_unique(r, i);
					fill(r, i);
					r.status = ipv6_dad_pkg::ST_OK;
					break;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// result checker
	always @(posedge clk) begin
		ipv6_dad_pkg::dad_out_t w;
		if (arst_n && done) begin
			n_results++;
			if (expected_q.size() == 0) report("unexpected result", 64'd0, 64'd0);
			else begin
				w = expected_q.pop_front();
				if (result.status !== w.status)
					report("status", 64'(result.status), 64'(w.status));
				if (result.entry !== w.entry)
					report("entry", 64'(result.entry), 64'(w.entry));
				if (result.entry_state !== w.entry_state)
					report("entry_state", 64'(result.entry_state), 64'(w.entry_state));
				if (result.sent_count !== w.sent_count)
					report("sent_count", 64'(result.sent_count), 64'(w.sent_count));
				if (result.received_count !== w.received_count)
					report("received_count", 64'(result.received_count),
						64'(w.received_count));
				if (result.deadline !== w.deadline) report("deadline", result.deadline, w.deadline);
				if (result.send_kind !== w.send_kind)
					report("send_kind", 64'(result.send_kind), 64'(w.send_kind));
				if (result.verdict !== w.verdict)
					report("verdict", 64'(result.verdict), 64'(w.verdict));
				if (result.ip_down !== w.ip_down)
					report("ip_down", 64'(result.ip_down), 64'(w.ip_down));
				if (result.tentative !== w.tentative)
					report("tentative", 64'(result.tentative), 64'(w.tentative));
				if (result.target_hi !== w.target_hi)
					report("target_hi", result.target_hi, w.target_hi);
				if (result.target_lo !== w.target_lo)
					report("target_lo", result.target_lo, w.target_lo);
			end
		end
	end

	// one transaction on the command port
	task automatic send_item(input ipv6_dad_pkg::dad_in_t x);
		if (idle_on && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 19)) @(posedge clk);
		while (busy) @(posedge clk);
		start <= 1'b1;
		item <= x;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_q.push_back(dad_predict(x));
		n_items++;
		start <= 1'b0;
		item <= '0;
		@(posedge clk);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		while (expected_q.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (20) @(posedge clk);
	endtask

	// register write, only when idle
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			ipv6_dad_pkg::REG_TRANSMIT: c_xmit = val[7:0];
			ipv6_dad_pkg::REG_LOOPBACK: c_loop = val[0];
			ipv6_dad_pkg::REG_RETRANS:  c_retr = val;
			ipv6_dad_pkg::REG_MAXDELAY: c_maxd = val[15:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic ipv6_dad_pkg::dad_in_t make_item(input logic [2:0] act, input int p);
		ipv6_dad_pkg::dad_in_t x;
		x = '0;
		x.action = act;
		x.addr_hi = pool_hi[p];
		x.addr_lo = pool_lo[p];
		x.now_ms = now_clk;
		x.rexmit_ms = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom_range(1, 40));
		x.rand_word = 16'($urandom);
		x.use_delay = 1'($urandom);
		x.hw_based = 1'($urandom);
		x.src_unspecified = $urandom_range(0, 3) != 0;
		return x;
	endfunction

	task automatic new_pool();
		for (int p = 0; p < 6; p++) begin
			pool_hi[p] = {$urandom, $urandom};
			pool_lo[p] = {$urandom, $urandom};
			if (pool_hi[p][63:56] == 8'hFF) pool_hi[p][63:56] = 8'h20;
		end
		pool_hi[0] = {16'hFE80, 48'd0};
	endtask

	// directed: refusals, extremes, every action
	task automatic test_directed();
		ipv6_dad_pkg::dad_in_t x;
		new_pool();
		x = make_item(ipv6_dad_pkg::ACT_START, 0);
		x.addr_hi = '1; send_item(x);
		x.addr_hi = '0; x.addr_lo = '0; send_item(x);
		x = make_item(ipv6_dad_pkg::ACT_START, 1); x.is_anycast = 1; send_item(x);
		x = make_item(ipv6_dad_pkg::ACT_STOP, 1); send_item(x);
		x = make_item(ipv6_dad_pkg::ACT_FIND, 1); send_item(x);
		x = make_item(ipv6_dad_pkg::ACT_NS, 1); send_item(x);
		x.action = ACT_UNDEF_A; send_item(x);
		x.action = ACT_UNDEF_B; send_item(x);
		x = make_item(ipv6_dad_pkg::ACT_TICK, 0); send_item(x);
		x = make_item(ipv6_dad_pkg::ACT_START, 0); x.hw_based = 1; x.use_delay = 1;
		x.rand_word = 16'hFFFF; x.rexmit_ms = 32'hFFFF_FFFF; x.now_ms = 32'hFFFF_FFF0;
		send_item(x);
		x.addr_lo = 64'hFFFF_FFFF_FFFF_FFFF; x.addr_hi = 64'hFEBF_FFFF_FFFF_FFFF;
		x.rexmit_ms = '0; x.now_ms = '0; send_item(x);
		x = make_item(ipv6_dad_pkg::ACT_START, 0); send_item(x);
		x = make_item(ipv6_dad_pkg::ACT_NS, 0); x.src_unspecified = 1; send_item(x);
		x = make_item(ipv6_dad_pkg::ACT_FIND, 0); send_item(x);
		// fill the table until it reports full
		for (int k = 0; k < 8; k++) begin
			x = make_item(ipv6_dad_pkg::ACT_START, 1);
			x.addr_lo = 64'(k); send_item(x);
		end
		x = make_item(ipv6_dad_pkg::ACT_TICK, 1); x.now_ms = 32'hFFFF_FFFF; send_item(x);
		x = make_item(ipv6_dad_pkg::ACT_NA, 1); x.addr_lo = '0; send_item(x);
		x = make_item(ipv6_dad_pkg::ACT_STOP, 1); x.addr_lo = 64'd1; send_item(x);
	endtask

	// random lifecycles over a small address pool, with some malformed commands mixed in
	task automatic test_random(input int count);
		ipv6_dad_pkg::dad_in_t x;
		int p, sel;
		for (int k = 0; k < count; k++) begin
			p = $urandom_range(0, 5);
			sel = $urandom_range(0, 99);
			if (sel < 45) begin
				now_clk = now_clk + 32'($urandom_range(0, 30));
				if ($urandom_range(0, 40) == 0) now_clk = $urandom;
				x = make_item(ipv6_dad_pkg::ACT_TICK, p);
			end else if (sel < 60) x = make_item(ipv6_dad_pkg::ACT_START, p);
			else if (sel < 70) x = make_item(ipv6_dad_pkg::ACT_STOP, p);
			else if (sel < 78) x = make_item(ipv6_dad_pkg::ACT_FIND, p);
			else if (sel < 88) x = make_item(ipv6_dad_pkg::ACT_NS, p);
			else if (sel < 94) x = make_item(ipv6_dad_pkg::ACT_NA, p);
			else begin
				x = make_item(3'($urandom_range(0, 7)), p);
				x.addr_hi = {$urandom, $urandom};
				x.addr_lo = {$urandom, $urandom};
				x.now_ms = now_clk;
				x.is_anycast = 1'($urandom);
			end
			send_item(x);
		end
	endtask

	// stop every pooled address, and the low words 0 to 7 under pool address 1
	task automatic test_flush();
		for (int p = 0; p < 6; p++) send_item(make_item(ipv6_dad_pkg::ACT_STOP, p));
		for (int k = 0; k < 8; k++) begin
			ipv6_dad_pkg::dad_in_t x;
			x = make_item(ipv6_dad_pkg::ACT_STOP, 1);
			x.addr_lo = 64'(k);
			send_item(x);
		end
	endtask

	initial begin
		start = 0;
		item = '0;
		cfg_valid = 0;
		cfg_index = ipv6_dad_pkg::REG_TRANSMIT;
		cfg_data = '0;
		arst_n = 0;
		for (int i = 0; i < NSLOT; i++) clear_entry(i);
		clk_lo = '0; clk_hi = '0;
		c_xmit = 8'd1; c_loop = 0; c_retr = 32'd1000; c_maxd = 16'd1000;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		test_directed();
		write_reg(ipv6_dad_pkg::REG_TRANSMIT, 32'd3);
		write_reg(ipv6_dad_pkg::REG_LOOPBACK, 32'd1);
		write_reg(ipv6_dad_pkg::REG_RETRANS, 32'd20);
		write_reg(ipv6_dad_pkg::REG_MAXDELAY, 32'd40);
		test_flush();
		new_pool();
		test_random(120);
		// hold off until everything is back
		drain();
		test_random(30);
		write_reg(ipv6_dad_pkg::REG_TRANSMIT, 32'd0);
		write_reg(ipv6_dad_pkg::REG_LOOPBACK, 32'd0);
		write_reg(ipv6_dad_pkg::REG_MAXDELAY, 32'd0);
		test_flush();
		new_pool();
		test_random(60);
		write_reg(ipv6_dad_pkg::REG_TRANSMIT, 32'd255);
		write_reg(ipv6_dad_pkg::REG_RETRANS, 32'hFFFF_FFFF);
		write_reg(ipv6_dad_pkg::REG_MAXDELAY, 32'h0000_FFFF);
		test_flush();
		test_random(60);
		write_reg(ipv6_dad_pkg::REG_TRANSMIT, 32'd1);
		write_reg(ipv6_dad_pkg::REG_RETRANS, 32'd1);
		write_reg(ipv6_dad_pkg::REG_MAXDELAY, 32'd10);
		test_flush();
		new_pool();
		test_random(100);
		idle_on = 0;
		test_random(100);
		drain();

		$display("covered %0d commands and %0d results over five register settings",
			n_items, n_results);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule

### sim.f
design/ipv6_dad_pkg.sv
design/ipv6_dad_ctrl.sv
design/ipv6_dad_dp.sv
design/ipv6_dad_table_machine.sv
tb/tb_ipv6_dad_table_machine.sv
